### sv/bounded_edit_distance_unit_assert.svh
// Assertion macros shared by the bounded edit distance unit.
`ifndef BOUNDED_EDIT_DISTANCE_UNIT_ASSERT_SVH
`define BOUNDED_EDIT_DISTANCE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define BED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bed_pkg.sv
// Types and constants of the bounded edit distance unit.
package bed_pkg;

  localparam int CharW = 8;
  localparam int DistW = 7;

  typedef struct packed {
    logic [CharW-1:0] char_a;
    logic             a_present;
    logic [CharW-1:0] char_b;
    logic             b_present;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             is_close;
    logic             too_long;
  } out_item_t;

  // Back end hands a string bank back to the front end.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // Register word index (paddr[2]) and reset value.
  localparam logic       RegMaxDistance = 1'b0;
  localparam logic [DistW-1:0] MaxDistanceRst = 7'd1;

endpackage

### sv/bed_ifs.sv
// Valid/ready stream interfaces for input items and result items.
interface bed_in_if import bed_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bed_out_if import bed_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### sv/bed_job_fifo.sv
// Two-entry queue of loaded string pairs between front and back end.
module bed_job_fifo import bed_pkg::*; #(
  parameter int Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [Width-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign empty_o    = (count_q == 2'd0);
  assign full_o     = (count_q == 2'd2);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/bed_front.sv
// Front end: accept items, append characters to the current bank, queue pairs.
module bed_front import bed_pkg::*; #(
  parameter int MaxLen = 64,
  parameter int LenW   = 7,
  parameter int AdrW   = 7,
  parameter int JobW   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bed_in_if.sink           in_i,
  output logic             a_we_o,
  output logic [AdrW-1:0]  a_waddr_o,
  output logic [CharW-1:0] a_wdata_o,
  output logic             b_we_o,
  output logic [AdrW-1:0]  b_waddr_o,
  output logic [CharW-1:0] b_wdata_o,
  output logic             job_push_o,
  output logic [JobW-1:0]  job_data_o,
  input  logic             job_full_i,
  input  bank_rel_t        release_i
);

  logic            bank_q, bank_d;
  logic [LenW-1:0] len_a_q, len_a_d, len_a_nx;
  logic [LenW-1:0] len_b_q, len_b_d, len_b_nx;
  logic            ovf_q, ovf_d, ovf_nx;
  logic [1:0]      busy_q, busy_d;
  logic            accept, a_full, b_full;

  assign in_i.ready = !busy_q[bank_q] && !job_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign a_full     = (len_a_q == LenW'(MaxLen));
  assign b_full     = (len_b_q == LenW'(MaxLen));

  assign a_we_o    = accept && in_i.item.a_present && !a_full;
  assign b_we_o    = accept && in_i.item.b_present && !b_full;
  assign a_waddr_o = {bank_q, len_a_q[AdrW-2:0]};
  assign b_waddr_o = {bank_q, len_b_q[AdrW-2:0]};
  assign a_wdata_o = in_i.item.char_a;
  assign b_wdata_o = in_i.item.char_b;

  assign len_a_nx = len_a_q + LenW'(a_we_o);
  assign len_b_nx = len_b_q + LenW'(b_we_o);
  // Flag a present character that finds its string already full.
  assign ovf_nx   = ovf_q
                  || (accept && in_i.item.a_present && a_full)
                  || (accept && in_i.item.b_present && b_full);

  assign job_push_o = accept && in_i.item.last;
  assign job_data_o = {bank_q, len_a_nx, len_b_nx, ovf_nx};

  always_comb begin
    bank_d  = bank_q;
    len_a_d = len_a_nx;
    len_b_d = len_b_nx;
    ovf_d   = ovf_nx;
    busy_d  = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (job_push_o) begin
      busy_d[bank_q] = 1'b1;
      bank_d         = !bank_q;
      len_a_d        = '0;
      len_b_d        = '0;
      ovf_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      len_a_q <= '0;
      len_b_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 2'b00;
    end else begin
      bank_q  <= bank_d;
      len_a_q <= len_a_d;
      len_b_q <= len_b_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
    end
  end

endmodule

### sv/bed_back.sv
// Back end: string banks, row-by-row cost update, result register.
module bed_back import bed_pkg::*; #(
  parameter int MaxLen = 64,
  parameter int LenW   = 7,
  parameter int AdrW   = 7,
  parameter int CostW  = 7,
  parameter int JobW   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             a_we_i,
  input  logic [AdrW-1:0]  a_waddr_i,
  input  logic [CharW-1:0] a_wdata_i,
  input  logic             b_we_i,
  input  logic [AdrW-1:0]  b_waddr_i,
  input  logic [CharW-1:0] b_wdata_i,
  input  logic             job_valid_i,
  input  logic [JobW-1:0]  job_data_i,
  output logic             job_pop_o,
  input  logic [DistW-1:0] max_distance_i,
  output bank_rel_t        release_o,
  bed_out_if.source        out_o
);

  localparam int IdxW  = AdrW - 1;
  localparam int CmpW  = (CostW > DistW) ? CostW : DistW;
  localparam int BankD = 2 ** AdrW;
  localparam int ColD  = MaxLen;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRow  = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [CharW-1:0] mem_a [BankD];
  logic [CharW-1:0] mem_b [BankD];
  logic [CostW-1:0] mem_col [ColD];

  logic [1:0]       st_q, st_d;
  logic             cv_q, cv_d;
  logic             out_valid_q, out_valid_d;
  logic             bank_q;
  logic [LenW-1:0]  la_q, lb_q, i_q, j_q, cj_q;
  logic             ovf_q;
  logic [CostW-1:0] diag_q, left_q, res_q;
  logic [CharW-1:0] a_rd_q, b_rd_q;
  logic [CostW-1:0] col_rd_q;
  out_item_t        out_q;

  logic             job_bank, job_ovf;
  logic [LenW-1:0]  job_la, job_lb;
  logic             issue, row_end, last_row, out_free;
  logic [CostW-1:0] up, sub, new_cost, m1;
  logic [CmpW-1:0]  res_ext, md_ext;
  logic             close;

  assign {job_bank, job_la, job_lb, job_ovf} = job_data_i;

  // Storage: writes from the front end, registered reads here.
  always_ff @(posedge clk_i) begin
    if (a_we_i) begin
      mem_a[a_waddr_i] <= a_wdata_i;
    end
    a_rd_q <= mem_a[{bank_q, i_q[IdxW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (b_we_i) begin
      mem_b[b_waddr_i] <= b_wdata_i;
    end
    b_rd_q <= mem_b[{bank_q, j_q[IdxW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StRun && cv_q) begin
      mem_col[cj_q[IdxW-1:0]] <= new_cost;
    end
    col_rd_q <= mem_col[j_q[IdxW-1:0]];
  end

  assign issue    = (st_q == StRun) && (j_q != lb_q);
  assign row_end  = cv_q && (cj_q == lb_q - LenW'(1));
  assign last_row = (i_q == la_q - LenW'(1));

  // Cell update; the first row sees the empty-prefix costs instead of memory.
  always_comb begin
    up       = (i_q == '0) ? CostW'(cj_q) + CostW'(1) : col_rd_q;
    sub      = diag_q + CostW'(a_rd_q != b_rd_q);
    m1       = (up < left_q) ? up + CostW'(1) : left_q + CostW'(1);
    new_cost = (sub < m1) ? sub : m1;
  end

  assign res_ext  = CmpW'(res_q);
  assign md_ext   = CmpW'(max_distance_i);
  assign close    = res_ext < md_ext;
  assign out_free = !out_valid_q || out_o.ready;

  assign job_pop_o       = (st_q == StIdle) && job_valid_i;
  assign release_o.valid = (st_q == StFin) && out_free;
  assign release_o.bank  = bank_q;

  always_comb begin
    st_d        = st_q;
    cv_d        = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    case (st_q)
      StIdle: begin
        if (job_valid_i) begin
          st_d = (job_la == '0 || job_lb == '0) ? StFin : StRow;
        end
      end
      StRow: begin
        st_d = StRun;
      end
      StRun: begin
        cv_d = issue;
        if (row_end) begin
          st_d = last_row ? StFin : StRow;
        end
      end
      StFin: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          st_d        = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      cv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cv_q        <= cv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        bank_q <= job_bank;
        la_q   <= job_la;
        lb_q   <= job_lb;
        ovf_q  <= job_ovf;
        i_q    <= '0;
        // An empty string leaves the other length as the distance.
        res_q  <= (job_la == '0) ? CostW'(job_lb) : CostW'(job_la);
      end
      StRow: begin
        j_q    <= '0;
        diag_q <= CostW'(i_q);
        left_q <= CostW'(i_q) + CostW'(1);
      end
      StRun: begin
        cj_q <= j_q;
        if (issue) begin
          j_q <= j_q + LenW'(1);
        end
        if (cv_q) begin
          diag_q <= up;
          left_q <= new_cost;
          if (row_end) begin
            if (last_row) begin
              res_q <= new_cost;
            end else begin
              i_q <= i_q + LenW'(1);
            end
          end
        end
      end
      StFin: begin
        if (out_free) begin
          out_q.distance <= close ? DistW'(res_q) : max_distance_i;
          out_q.is_close <= close;
          out_q.too_long <= ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

endmodule

### sv/bounded_edit_distance_unit.sv
// Top level of the bounded edit distance unit: front end, pair queue, back end, register.
// Items stream in one per cycle, each adding a character to either or both strings of a
// pair; the item with last set closes the pair and yields exactly one result: the
// Levenshtein distance of the two strings (unit cost insert, delete, substitute),
// saturated at max_distance, with is_close when the exact distance is below
// max_distance and too_long when either string got more than MaxLen characters (extra
// characters are dropped). Two string banks let a new pair load while the previous pair
// is computed; loading stalls only when both banks are in use. The back end updates one
// cost cell per cycle within a row, with a StRow setup step before each row. The
// max_distance register lives at byte address 0 of the APB port (reset value 1); the
// user must write it only while the unit is idle; the unit does not enforce this. No
// clearing pass follows reset.
module bounded_edit_distance_unit import bed_pkg::*; #(
  parameter int MaxLen = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bed_in_if.sink      in_i,
  bed_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "bounded_edit_distance_unit_assert.svh"

  localparam int LenW  = $clog2(MaxLen + 1);
  localparam int AdrW  = $clog2(MaxLen) + 1;
  localparam int CostW = $clog2(MaxLen + 2);
  localparam int JobW  = 2 * LenW + 2;

  logic             a_we, b_we;
  logic [AdrW-1:0]  a_waddr, b_waddr;
  logic [CharW-1:0] a_wdata, b_wdata;
  logic             job_push, job_pop, job_empty, job_full;
  logic [JobW-1:0]  job_in, job_out;
  bank_rel_t        bank_rel;
  logic [DistW-1:0] max_distance_q, max_distance_d;
  logic             reg_hit;

  // Register port: writes land on the access phase, reads return the threshold at word 0 and zero elsewhere.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == RegMaxDistance);
  assign prdata  = reg_hit ? 32'(max_distance_q) : 32'd0;

  always_comb begin
    max_distance_d = max_distance_q;
    if (psel && penable && pwrite && reg_hit) begin
      max_distance_d = pwdata[DistW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_distance_q <= MaxDistanceRst;
    end else begin
      max_distance_q <= max_distance_d;
    end
  end

  bed_front #(
    .MaxLen (MaxLen),
    .LenW   (LenW),
    .AdrW   (AdrW),
    .JobW   (JobW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .a_we_o     (a_we),
    .a_waddr_o  (a_waddr),
    .a_wdata_o  (a_wdata),
    .b_we_o     (b_we),
    .b_waddr_o  (b_waddr),
    .b_wdata_o  (b_wdata),
    .job_push_o (job_push),
    .job_data_o (job_in),
    .job_full_i (job_full),
    .release_i  (bank_rel)
  );

  // Hold closed pairs until the back end frees up.
  bed_job_fifo #(
    .Width (JobW)
  ) u_job_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .pop_i       (job_pop),
    .pop_data_o  (job_out),
    .empty_o     (job_empty),
    .full_o      (job_full)
  );

  bed_back #(
    .MaxLen (MaxLen),
    .LenW   (LenW),
    .AdrW   (AdrW),
    .CostW  (CostW),
    .JobW   (JobW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .a_we_i         (a_we),
    .a_waddr_i      (a_waddr),
    .a_wdata_i      (a_wdata),
    .b_we_i         (b_we),
    .b_waddr_i      (b_waddr),
    .b_wdata_i      (b_wdata),
    .job_valid_i    (!job_empty),
    .job_data_i     (job_out),
    .job_pop_o      (job_pop),
    .max_distance_i (max_distance_q),
    .release_o      (bank_rel),
    .out_o          (out_o)
  );

  `BED_ASSERT_NOW(a_no_push_full, job_push, !job_full, "pair pushed into full queue")
  `BED_ASSERT_NOW(a_no_pop_empty, job_pop, !job_empty, "pair popped from empty queue")
  `BED_ASSERT_NEXT(a_release_shows, bank_rel.valid, out_o.valid, "bank freed without result")

endmodule
